// ===== design/float_band_table_defines.svh =====
// Assertion macros shared by the float band table design.
// Included by the top level; no other dependencies.
`ifndef FLOAT_BAND_TABLE_DEFINES_SVH
`define FLOAT_BAND_TABLE_DEFINES_SVH
// implication checked on every rising clock edge outside reset
`define FBT_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("float_band_table check failed");
// next-cycle implication
`define FBT_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("float_band_table check failed");
`endif

// ===== design/fbt_pkg.sv =====
// Shared types, operation codes and helpers of the float band table.
// No dependencies.
package fbt_pkg;
	localparam int MaxEntries = 64;
	localparam int IdxW = $clog2(MaxEntries);
	localparam int CntW = $clog2(MaxEntries + 1);

	localparam logic [2:0] FUNC_APPEND = 3'd0;
	localparam logic [2:0] FUNC_QUERY  = 3'd1;
	localparam logic [2:0] FUNC_CLEAR  = 3'd2;
	localparam logic [2:0] FUNC_TRUNC  = 3'd3;
	localparam logic [2:0] FUNC_LOWTOP = 3'd4;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_BADN = 2'd2;

	localparam logic signed [31:0] SMAX = 32'sh7fffffff;
	localparam logic signed [31:0] SMIN = 32'sh80000000;
	localparam logic [30:0] UMAX31 = 31'h7fffffff;

	typedef struct packed {
		logic signed [31:0] left;
		logic signed [31:0] top;
		logic [30:0] width;
		logic [30:0] height;
		logic side;
		logic signed [31:0] lbm;
		logic signed [31:0] rbm;
	} entry_t;

	// saturate a 34-bit signed value to 32 bits
	function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
		if (v > 34'sh07fffffff) return SMAX;
		if (v < -34'sh080000000) return SMIN;
		return v[31:0];
	endfunction

	function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
		input logic signed [31:0] b);
		return sat34(34'(a) + 34'(b));
	endfunction

	function automatic logic signed [31:0] sub_sat(input logic signed [31:0] a,
		input logic signed [31:0] b);
		return sat34(34'(a) - 34'(b));
	endfunction

	function automatic logic signed [31:0] addu_sat(input logic signed [31:0] a,
		input logic [30:0] b);
		return sat34(34'(a) + $signed({3'b000, b}));
	endfunction
endpackage

// ===== design/fbt_mem.sv =====
// Entry store of the float band table: one write port, one registered read port.
// Depends on fbt_pkg.
module fbt_mem import fbt_pkg::*; (
	input  logic clk,
	input  logic we,
	input  logic [IdxW-1:0] waddr,
	input  entry_t wdata,
	input  logic [IdxW-1:0] raddr,
	output entry_t rdata
);
	entry_t mem [MaxEntries];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== design/float_band_table.sv =====
// Float band table: ordered store of left and right float rectangles with running
// bottom maxima, answering flow-area band queries, clearance and state pop requests.
// One request is handled at a time. Append, clear and lowest top read the newest
// entry, then act on it (append writes the new entry); truncate and unknown codes
// go straight to the result; a flow-area query reads one entry per cycle walking
// back from the newest, stopping early or at the limit. The result sits in an
// output register; the next request is taken once the result has been delivered.
// Depends on fbt_pkg, fbt_mem and float_band_table_defines.svh.
`include "float_band_table_defines.svh"
module float_band_table import fbt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic cfg_index,
	input  logic [31:0] cfg_data,
	input  logic in_valid,
	output logic in_ready,
	input  logic [2:0] func,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic [30:0] rect_width,
	input  logic [30:0] rect_height,
	input  logic side,
	input  logic band_mode,
	input  logic [1:0] break_side,
	input  logic limit_valid,
	input  logic [6:0] limit_count,
	output logic out_valid,
	input  logic out_ready,
	output logic [1:0] status,
	output logic signed [31:0] area_x,
	output logic signed [31:0] area_y,
	output logic [30:0] area_width,
	output logic [30:0] area_height,
	output logic has_floats,
	output logic signed [31:0] result_y,
	output logic [6:0] entry_count
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD   = 3'd1;
	localparam logic [2:0] S_EXEC = 3'd2;
	localparam logic [2:0] S_WALK = 3'd3;
	localparam logic [2:0] S_FIN  = 3'd4;
	localparam logic [2:0] S_OUT  = 3'd5;

	logic [2:0] state_q;
	logic signed [31:0] org_x_q, org_y_q;
	logic [CntW-1:0] count_q;
	logic [2:0] func_q;
	logic signed [31:0] px_q, py_q;
	logic [30:0] w_q, h_q;
	logic side_q, mode_q;
	logic [1:0] brk_q;
	logic [CntW-1:0] n_q;     // entries still to visit
	logic [1:0] status_q;
	logic signed [31:0] top_q, bot_q, ax_q, ay_q, ry_q;
	logic signed [32:0] left_q, right_q;
	logic [30:0] aw_q, ah_q;
	logic hf_q;

	logic mem_we;
	logic [IdxW-1:0] mem_waddr, mem_raddr;
	entry_t mem_wdata, rd;

	fbt_mem u_mem (
		.clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
		.raddr(mem_raddr), .rdata(rd)
	);

	assign cfg_ready = (state_q == S_IDLE);
	assign in_ready  = (state_q == S_IDLE) && !cfg_valid;
	assign out_valid = (state_q == S_OUT);

	logic in_acc;
	assign in_acc = in_valid && in_ready;

	// walk stepping: entries to visit and status of the incoming request; read address is n-1 outside the walk
	logic [CntW-1:0] n_in;
	logic [1:0] st_in;
	always_comb begin
		n_in = count_q;
		st_in = ST_OK;
		if (func == FUNC_QUERY && limit_valid) begin
			if (CntW'(limit_count) > count_q || limit_count > 7'(MaxEntries)) begin
				st_in = ST_BADN;
			end else begin
				n_in = CntW'(limit_count);
			end
		end else if (func == FUNC_TRUNC) begin
			if (CntW'(limit_count) > count_q || limit_count > 7'(MaxEntries)) begin
				st_in = ST_BADN;
			end
		end
	end
	logic [CntW-1:0] n_cur;
	assign n_cur = (state_q == S_IDLE) ? n_in : n_q;
	logic [CntW-1:0] n_dec;
	assign n_dec = n_cur - CntW'(1);
	// while evaluating entry n-1, fetch entry n-2 for the next cycle
	always_comb begin
		mem_raddr = n_dec[IdxW-1:0];
		if (state_q inside {S_EXEC, S_WALK}) begin
			mem_raddr = n_q[IdxW-1:0] - IdxW'(2);
		end
	end

	// per-entry evaluation
	logic signed [31:0] fb, re, nbot;
	logic signed [32:0] nleft, nright;
	logic nhf, stop, empty;
	always_comb begin
		fb = addu_sat(rd.top, rd.height);
		re = addu_sat(rd.left, rd.width);
		nbot = bot_q;
		nleft = left_q;
		nright = right_q;
		nhf = hf_q;
		stop = (rd.lbm <= top_q) && (rd.rbm <= top_q);
		empty = (rd.width == '0) || (rd.height == '0);
		if (!empty) begin
			if (top_q < rd.top && !mode_q) begin
				if (rd.top < nbot) nbot = rd.top;
			end else if (top_q < fb && (rd.top < bot_q ||
					(rd.top == bot_q && top_q == bot_q))) begin
				if (fb < nbot && !mode_q) nbot = fb;
				if (!rd.side) begin
					if (33'(re) > left_q) begin
						nleft = 33'(re);
						nhf = 1'b1;
					end
				end else if (33'(rd.left) > left_q || 33'(rd.left) < right_q) begin
					if (33'(rd.left) < right_q) begin
						nright = 33'(rd.left);
						nhf = 1'b1;
					end
				end
			end
		end
	end

	// append write data
	logic signed [31:0] a_bot;
	always_comb begin
		mem_wdata.left = add_sat(px_q, org_x_q);
		mem_wdata.top = add_sat(py_q, org_y_q);
		mem_wdata.width = w_q;
		mem_wdata.height = h_q;
		mem_wdata.side = side_q;
		a_bot = addu_sat(mem_wdata.top, h_q);
		mem_wdata.lbm = (count_q == '0) ? SMIN : rd.lbm;
		mem_wdata.rbm = (count_q == '0) ? SMIN : rd.rbm;
		if (!side_q) begin
			if (a_bot > mem_wdata.lbm) mem_wdata.lbm = a_bot;
		end else if (a_bot > mem_wdata.rbm) begin
			mem_wdata.rbm = a_bot;
		end
		mem_waddr = count_q[IdxW-1:0];
		mem_we = (state_q == S_EXEC) && (func_q == FUNC_APPEND) &&
			(count_q < CntW'(MaxEntries));
	end

	logic signed [33:0] hdiff;
	logic signed [33:0] wdiff;
	assign hdiff = 34'(bot_q) - 34'(top_q);
	assign wdiff = 34'(right_q) - 34'(left_q);
	logic signed [31:0] clr_b;
	always_comb begin
		clr_b = add_sat(py_q, org_y_q);
		if (brk_q[0] && rd.lbm > clr_b) clr_b = rd.lbm;
		if (brk_q[1] && rd.rbm > clr_b) clr_b = rd.rbm;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			org_x_q <= '0;
			org_y_q <= '0;
			func_q <= '0;
			px_q <= '0;
			py_q <= '0;
			w_q <= '0;
			h_q <= '0;
			side_q <= 1'b0;
			mode_q <= 1'b0;
			brk_q <= '0;
			n_q <= '0;
			status_q <= ST_OK;
			top_q <= '0;
			bot_q <= '0;
			left_q <= '0;
			right_q <= '0;
			hf_q <= 1'b0;
			ax_q <= '0;
			ay_q <= '0;
			aw_q <= '0;
			ah_q <= '0;
			ry_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (!cfg_index) org_x_q <= cfg_data;
				else org_y_q <= cfg_data;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						// request payload capture
						func_q <= func;
						px_q <= pos_x;
						py_q <= pos_y;
						w_q <= rect_width;
						h_q <= rect_height;
						side_q <= side;
						mode_q <= band_mode;
						brk_q <= break_side;
						n_q <= n_in;
						status_q <= st_in;
						top_q <= add_sat(pos_y, org_y_q);
						bot_q <= (rect_height == UMAX31) ? SMAX :
							addu_sat(add_sat(pos_y, org_y_q), rect_height);
						left_q <= 33'(org_x_q);
						right_q <= 33'(addu_sat(org_x_q, rect_width));
						hf_q <= 1'b0;
						ax_q <= '0;
						ay_q <= '0;
						aw_q <= '0;
						ah_q <= '0;
						ry_q <= '0;
						if (func == FUNC_TRUNC) begin
							state_q <= S_OUT;
							if (st_in == ST_OK) count_q <= CntW'(limit_count);
						end else if (func > FUNC_LOWTOP) begin
							state_q <= S_OUT;
						end else begin
							state_q <= S_RD;
						end
					end
				end
				S_RD: state_q <= S_EXEC;
				S_EXEC: begin
					state_q <= S_OUT;
					case (func_q)
						FUNC_APPEND: begin
							if (count_q >= CntW'(MaxEntries)) status_q <= ST_FULL;
							else count_q <= count_q + CntW'(1);
						end
						FUNC_QUERY: begin
							if (n_q == '0 || stop) begin
								ax_q <= '0;
								ay_q <= py_q;
								aw_q <= w_q;
								ah_q <= h_q;
								hf_q <= 1'b0;
							end else begin
								bot_q <= nbot;
								left_q <= nleft;
								right_q <= nright;
								hf_q <= nhf;
								n_q <= n_q - CntW'(1);
								state_q <= (n_q == CntW'(1)) ? S_FIN : S_WALK;
							end
						end
						FUNC_CLEAR: ry_q <= (count_q == '0) ? py_q : sub_sat(clr_b, org_y_q);
						default: ry_q <= (count_q == '0) ? SMIN : sub_sat(rd.top, org_y_q);
					endcase
				end
				S_WALK: begin
					if (stop) begin
						state_q <= S_FIN;
					end else begin
						bot_q <= nbot;
						left_q <= nleft;
						right_q <= nright;
						hf_q <= nhf;
						n_q <= n_q - CntW'(1);
						if (n_q == CntW'(1)) state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (bot_q == SMAX) ah_q <= UMAX31;
					else if (hdiff > 34'sh07fffffff) ah_q <= UMAX31;
					else if (hdiff < 0) ah_q <= '0;
					else ah_q <= hdiff[30:0];
					aw_q <= (wdiff > 0) ? wdiff[30:0] : '0;
					ax_q <= sat34(34'(left_q) - 34'(org_x_q));
					ay_q <= sub_sat(top_q, org_y_q);
					state_q <= S_OUT;
				end
				S_OUT: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign status = status_q;
	assign area_x = ax_q;
	assign area_y = ay_q;
	assign area_width = aw_q;
	assign area_height = ah_q;
	assign has_floats = hf_q;
	assign result_y = ry_q;
	assign entry_count = 7'(count_q);

	`FBT_ASSERT_IMP(a_count_range, 1'b1, count_q <= CntW'(MaxEntries))
	`FBT_ASSERT_IMP(a_no_ready_busy, out_valid, !in_ready)
	`FBT_ASSERT_NXT(a_write_bumps, mem_we, count_q == $past(count_q) + CntW'(1))
endmodule

// ===== tb/float_band_table_checker.sv =====
// Watches the request, config and result channels of the float band table,
// predicts each result from its own model of the table, and counts mismatches.
// Depends on fbt_pkg.
`timescale 1ns / 100ps
module float_band_table_checker import fbt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	input  logic cfg_ready,
	input  logic cfg_index,
	input  logic [31:0] cfg_data,
	input  logic in_valid,
	input  logic in_ready,
	input  logic [2:0] func,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic [30:0] rect_width,
	input  logic [30:0] rect_height,
	input  logic side,
	input  logic band_mode,
	input  logic [1:0] break_side,
	input  logic limit_valid,
	input  logic [6:0] limit_count,
	input  logic out_valid,
	input  logic out_ready,
	input  logic [1:0] status,
	input  logic signed [31:0] area_x,
	input  logic signed [31:0] area_y,
	input  logic [30:0] area_width,
	input  logic [30:0] area_height,
	input  logic has_floats,
	input  logic signed [31:0] result_y,
	input  logic [6:0] entry_count,
	output int errors,
	output int pending
);
	typedef struct packed {
		logic [1:0] status;
		logic signed [31:0] ax;
		logic signed [31:0] ay;
		logic [30:0] aw;
		logic [30:0] ah;
		logic hf;
		logic signed [31:0] ry;
		logic [6:0] cnt;
	} band_result_t;

	entry_t floats[MaxEntries];
	int unsigned nfloats;
	longint org_x, org_y;
	band_result_t band_results[$];

	localparam longint LMAX = 64'sd2147483647;
	localparam longint LMIN = -64'sd2147483648;

	function automatic longint clamp32(longint v);
		if (v > LMAX) return LMAX;
		if (v < LMIN) return LMIN;
		return v;
	endfunction

	function automatic longint float_bottom(int unsigned k);
		return clamp32(longint'(floats[k].top) + longint'(floats[k].height));
	endfunction

	function automatic band_result_t model_request();
		band_result_t r;
		int unsigned n;
		longint top, bot, lft, rgt, ft, fb, lb, rb, b;
		r = '0;
		case (func)
			FUNC_APPEND: begin
				if (nfloats >= MaxEntries) r.status = ST_FULL;
				else begin
					lb = LMIN;
					rb = LMIN;
					if (nfloats > 0) begin
						lb = floats[nfloats-1].lbm;
						rb = floats[nfloats-1].rbm;
					end
					floats[nfloats].left = clamp32(longint'(pos_x) + org_x);
					floats[nfloats].top = clamp32(longint'(pos_y) + org_y);
					floats[nfloats].width = rect_width;
					floats[nfloats].height = rect_height;
					floats[nfloats].side = side;
					b = float_bottom(nfloats);
					if (side == 0) begin
						if (b > lb) lb = b;
					end else if (b > rb) rb = b;
					floats[nfloats].lbm = lb;
					floats[nfloats].rbm = rb;
					nfloats++;
				end
			end
			FUNC_QUERY: begin
				top = clamp32(longint'(pos_y) + org_y);
				n = nfloats;
				if (limit_valid) begin
					if (limit_count > nfloats) r.status = ST_BADN;
					else n = limit_count;
				end
				if (n == 0 || (floats[n-1].lbm <= top && floats[n-1].rbm <= top)) begin
					r.ay = pos_y;
					r.aw = rect_width;
					r.ah = rect_height;
				end else begin
					bot = (rect_height == UMAX31) ? LMAX : clamp32(top + rect_height);
					lft = org_x;
					rgt = clamp32(longint'(rect_width) + org_x);
					for (int i = n; i > 0; i--) begin
						if (floats[i-1].lbm <= top && floats[i-1].rbm <= top) break;
						if (floats[i-1].width != 0 && floats[i-1].height != 0) begin
							ft = floats[i-1].top;
							fb = float_bottom(i-1);
							if (top < ft && band_mode == 0) begin
								if (ft < bot) bot = ft;
							end else if (top < fb && (ft < bot || (ft == bot && top == bot))) begin
								if (fb < bot && band_mode == 0) bot = fb;
								if (floats[i-1].side == 0) begin
									b = clamp32(longint'(floats[i-1].left) + floats[i-1].width);
									if (b > lft) begin
										lft = b;
										r.hf = 1;
									end
								end else if (floats[i-1].left < rgt) begin
									rgt = floats[i-1].left;
									r.hf = 1;
								end
							end
						end
					end
					if (bot == LMAX) r.ah = UMAX31;
					else if (bot - top > LMAX) r.ah = UMAX31;
					else if (bot - top < 0) r.ah = 0;
					else r.ah = bot - top;
					r.aw = (rgt > lft) ? rgt - lft : 0;
					r.ax = clamp32(lft - org_x);
					r.ay = clamp32(top - org_y);
				end
			end
			FUNC_CLEAR: begin
				if (nfloats == 0) r.ry = pos_y;
				else begin
					b = clamp32(longint'(pos_y) + org_y);
					if (break_side[0] && floats[nfloats-1].lbm > b) b = floats[nfloats-1].lbm;
					if (break_side[1] && floats[nfloats-1].rbm > b) b = floats[nfloats-1].rbm;
					r.ry = clamp32(b - org_y);
				end
			end
			FUNC_TRUNC: begin
				if (limit_count > nfloats) r.status = ST_BADN;
				else nfloats = limit_count;
			end
			FUNC_LOWTOP: begin
				r.ry = (nfloats == 0) ? LMIN : clamp32(longint'(floats[nfloats-1].top) - org_y);
			end
			default: ;
		endcase
		r.cnt = nfloats;
		return r;
	endfunction

	assign pending = band_results.size();

	always @(posedge clk or negedge arst_n) begin
		band_result_t e;
		if (!arst_n) begin
			nfloats = 0;
			org_x = 0;
			org_y = 0;
			errors = 0;
			band_results.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == 1'b0) org_x = $signed(cfg_data);
				else org_y = $signed(cfg_data);
			end
			if (in_valid && in_ready) band_results.push_back(model_request());
			if (out_valid && out_ready) begin
				if (band_results.size() == 0) begin
					$error("result with none expected");
					errors++;
				end else begin
					e = band_results.pop_front();
					if (status !== e.status) begin
						$error("status exp %0d got %0d", e.status, status); errors++;
					end
					if (area_x !== e.ax) begin
						$error("area_x exp %0d got %0d", e.ax, area_x); errors++;
					end
					if (area_y !== e.ay) begin
						$error("area_y exp %0d got %0d", e.ay, area_y); errors++;
					end
					if (area_width !== e.aw) begin
						$error("area_width exp %0d got %0d", e.aw, area_width); errors++;
					end
					if (area_height !== e.ah) begin
						$error("area_height exp %0d got %0d", e.ah, area_height); errors++;
					end
					if (has_floats !== e.hf) begin
						$error("has_floats exp %0d got %0d", e.hf, has_floats); errors++;
					end
					if (result_y !== e.ry) begin
						$error("result_y exp %0d got %0d", e.ry, result_y); errors++;
					end
					if (entry_count !== e.cnt) begin
						$error("entry_count exp %0d got %0d", e.cnt, entry_count); errors++;
					end
				end
			end
		end
	end
endmodule

// ===== tb/float_band_table_test.sv =====
// Top of the float band table testbench: clock, reset, request and config
// stimulus, result back-pressure and the verdict. Depends on fbt_pkg and the checker.
`timescale 1ns / 100ps
module float_band_table_test;
	import fbt_pkg::*;

	logic clk, arst_n;
	logic cfg_valid, cfg_ready, cfg_index;
	logic [31:0] cfg_data;
	logic in_valid, in_ready;
	logic [2:0] func;
	logic signed [31:0] pos_x, pos_y;
	logic [30:0] rect_width, rect_height;
	logic side, band_mode, limit_valid;
	logic [1:0] break_side;
	logic [6:0] limit_count;
	logic out_valid, out_ready;
	logic [1:0] status;
	logic signed [31:0] area_x, area_y, result_y;
	logic [30:0] area_width, area_height;
	logic has_floats;
	logic [6:0] entry_count;
	int errors, pending;
	int send_idle, recv_idle;
	int unsigned depth;

	float_band_table dut (.*);
	float_band_table_checker checker_i (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("*** FAILED ***");
		$finish;
	end

	always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_idle);

	function automatic logic [31:0] pick32();
		case ($urandom_range(5))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return $urandom;
			default: return $signed($urandom_range(400)) - 200;
		endcase
	endfunction

	function automatic logic [30:0] pick31();
		case ($urandom_range(5))
			0: return UMAX31;
			1: return 0;
			2: return $urandom;
			default: return $urandom_range(150);
		endcase
	endfunction

	// valid stays high across back-to-back requests; it drops only while idling or before an origin write
	task automatic send(logic [2:0] f, logic [31:0] x, logic [31:0] y, logic [30:0] w,
		logic [30:0] h, logic s, logic m, logic [1:0] bs, logic lv, logic [6:0] lc);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		func <= f; pos_x <= x; pos_y <= y; rect_width <= w; rect_height <= h;
		side <= s; band_mode <= m; break_side <= bs; limit_valid <= lv; limit_count <= lc;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (f == FUNC_APPEND && depth < MaxEntries) depth++;
		if (f == FUNC_TRUNC && lc <= depth) depth = lc;
	endtask

	task automatic random_request();
		int k;
		k = $urandom_range(99);
		if (k < 40)
			send(FUNC_APPEND, pick32(), pick32(), pick31(), pick31(), $urandom,
				0, 0, 0, 0);
		else if (k < 70)
			send(FUNC_QUERY, 0, pick32(), pick31(), pick31(), 0, $urandom, 0,
				$urandom, $urandom_range(depth + 2));
		else if (k < 80)
			send(FUNC_CLEAR, 0, pick32(), 0, 0, 0, 0, $urandom, 0, 0);
		else if (k < 88)
			send(FUNC_TRUNC, 0, 0, 0, 0, 0, 0, 0, 0,
				($urandom_range(3) == 0) ? $urandom : $urandom_range(depth));
		else if (k < 95)
			send(FUNC_LOWTOP, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		else
			send($urandom_range(7), $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom, $urandom);
	endtask

	task automatic write_origin(logic idx, logic [31:0] v);
		in_valid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (80) @(posedge clk);
		cfg_valid <= 1; cfg_index <= idx; cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 0;
	endtask

	initial begin
		arst_n = 0;
		cfg_valid = 0; cfg_index = 0; cfg_data = 0;
		in_valid = 0; func = 0; pos_x = 0; pos_y = 0; rect_width = 0; rect_height = 0;
		side = 0; band_mode = 0; break_side = 0; limit_valid = 0; limit_count = 0;
		out_ready = 0;
		depth = 0;
		send_idle = 9; recv_idle = 80;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// empty table corners, then a few floats, saturation and band edge cases, truncation, unknown codes and overfill
		send(FUNC_CLEAR, 0, 32'h80000000, 0, 0, 0, 0, 3, 0, 0);
		send(FUNC_LOWTOP, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		send(FUNC_QUERY, 0, 5, 100, UMAX31, 0, 0, 0, 0, 0);
		send(FUNC_APPEND, 0, 0, 50, 100, 0, 0, 0, 0, 0);
		send(FUNC_APPEND, 200, 10, 50, 100, 1, 0, 0, 0, 0);
		send(FUNC_APPEND, 30, 20, 0, 100, 0, 0, 0, 0, 0);
		send(FUNC_APPEND, 32'h7fffffff, 32'h7fffffff, UMAX31, UMAX31, 0, 0, 0, 0, 0);
		send(FUNC_APPEND, 32'h80000000, 32'h80000000, UMAX31, 5, 1, 0, 0, 0, 0);
		send(FUNC_APPEND, 10, 5, 300, 30, 0, 0, 0, 0, 0);
		send(FUNC_QUERY, 0, 0, 250, 40, 0, 0, 0, 0, 0);
		send(FUNC_QUERY, 0, 0, 250, UMAX31, 0, 1, 0, 0, 0);
		send(FUNC_QUERY, 0, 32'h7fffffff, UMAX31, UMAX31, 0, 0, 0, 1, 3);
		send(FUNC_QUERY, 0, 0, 10, 10, 0, 0, 0, 1, 64);
		send(FUNC_CLEAR, 0, 0, 0, 0, 0, 0, 1, 0, 0);
		send(FUNC_CLEAR, 0, 0, 0, 0, 0, 0, 2, 0, 0);
		send(FUNC_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		send(FUNC_LOWTOP, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		send(FUNC_TRUNC, 0, 0, 0, 0, 0, 0, 0, 0, 100);
		send(FUNC_TRUNC, 0, 0, 0, 0, 0, 0, 0, 0, 2);
		send(3'd5, 1, 1, 1, 1, 1, 1, 1, 1, 1);
		send(3'd7, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		for (int i = 0; i < 66; i++)
			send(FUNC_APPEND, i, i * 3, 10, 10, i[0], 0, 0, 0, 0);
		send(FUNC_QUERY, 0, 0, 500, UMAX31, 0, 0, 0, 0, 0);
		send(FUNC_TRUNC, 0, 0, 0, 0, 0, 0, 0, 0, 0);

		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin write_origin(0, 32'h7fffffff); write_origin(1, 32'h80000000); end
				1: begin write_origin(0, 32'h80000000); write_origin(1, 32'h7fffffff); end
				2: begin
					write_origin(0, $signed($urandom_range(200)) - 100);
					write_origin(1, $urandom);
					send_idle = 80; recv_idle = 9;
				end
				3: begin write_origin(0, $urandom); write_origin(1, 17); end
				default: begin
					write_origin(0, 0); write_origin(1, 0);
					send_idle = 0; recv_idle = 0;
				end
			endcase
			for (int i = 0; i < 200; i++) begin
				// occasionally pop back so queries don't always see a full table
				if ($urandom_range(40) == 0)
					send(FUNC_TRUNC, 0, 0, 0, 0, 0, 0, 0, 0, $urandom_range(depth));
				else random_request();
			end
		end

		in_valid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0) $display("*** PASSED ***");
		else $display("*** FAILED ***");
		$finish;
	end
endmodule
